// ----- rtl/client_hello_parse_and_find_ext_core_macros.svh -----
// assertion macros for the client hello parser core
`ifndef CLIENT_HELLO_PARSE_AND_FIND_EXT_CORE_MACROS_SVH
`define CLIENT_HELLO_PARSE_AND_FIND_EXT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every rising clock edge out of reset
`define CHP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CHP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CHP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/chp_pkg.sv -----
// shared types and constants of the client hello parser core
package chp_pkg;

   // message position counter width and saturation point
   localparam int unsigned POS_W       = 15;
   localparam int unsigned MAX_MSG_LEN = 16384;

   // layout constants
   localparam logic [23:0] MIN_PAYLOAD  = 24'd34;
   localparam logic [16:0] RANDOM_END   = 17'd38;
   localparam logic [14:0] LEN_END      = 15'd4;
   localparam logic [7:0]  HELLO_TYPE   = 8'd1;
   localparam logic [17:0] EXT_HDR_LEN  = 18'd4;
   localparam logic [24:0] MSG_HDR_LEN  = 25'd4;

   // configuration port
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic        CSR_IDX_TARGET = 1'b0;
   localparam logic [15:0] TARGET_RESET = 16'h0033;

   // parse phase of the message
   typedef enum logic [3:0] {
      PH_TYPE,
      PH_LEN,
      PH_RANDOM,
      PH_SIDLEN,
      PH_SID,
      PH_CSLEN,
      PH_CS,
      PH_COMPLEN,
      PH_COMP,
      PH_EXTLEN,
      PH_EXT,
      PH_DONE
   } phase_type;

   // result transaction, last field in the lowest bits
   typedef struct packed {
      logic        pad;
      logic [15:0] ext_data_len;
      logic [13:0] ext_data_offset;
      logic        ext_found;
      logic [15:0] ext_block_len;
      logic [13:0] ext_block_offset;
      logic        ext_block_present;
      logic [7:0]  compression_len;
      logic [15:0] cipher_suites_len;
      logic [7:0]  session_id_len;
      logic        hello_valid;
   } result_type;

endpackage

// ----- rtl/client_hello_parse_and_find_ext_core.sv -----
// client hello layout checker and extension finder, one message byte per cycle
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------------
//   req_     | in        | tdata: msg_byte, tlast: last_byte
//   rsp_     | out       | tdata: result fields, one transaction per message
//   csr_     | in/out    | target_ext_type at byte address 0
//
// one byte is taken every cycle unless stalled as below; the parse state updates in the same cycle
// the result of a message is in the output register the cycle after its last byte
// a last byte stalls only while an earlier result is held and not taken;
// other bytes keep flowing while a result waits
// synchronous reset clears the parse control state; the target type resets to key_share
`include "client_hello_parse_and_find_ext_core_macros.svh"

module client_hello_parse_and_find_ext_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tlast,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] hello_valid, [8:1] session_id_len, [24:9] cipher_suites_len,
   // [32:25] compression_len, [33] ext_block_present, [47:34] ext_block_offset,
   // [63:48] ext_block_len, [64] ext_found, [78:65] ext_data_offset,
   // [94:79] ext_data_len, [95] zero
   output logic [95:0] rsp_tdata,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [chp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration register
   logic [15:0] target_ff;

   // parse state
   chp_pkg::phase_type phase_ff, phase_in;
   logic [chp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [23:0] plen_ff, plen_in;
   logic [15:0] acc_ff, acc_in;
   logic [16:0] fend_ff, fend_in;
   logic [7:0]  sid_ff, sid_in;
   logic [15:0] cs_ff, cs_in;
   logic [7:0]  comp_ff, comp_in;
   logic [14:0] ebs_ff, ebs_in;
   logic [15:0] ebl_ff, ebl_in;
   logic [15:0] cur_ff, cur_in;
   logic        found_ff, found_in;
   logic [13:0] moff_ff, moff_in;
   logic [15:0] mlen_ff, mlen_in;
   logic        stop_ff, stop_in;
   logic        ferr_ff, ferr_in;

   // result register
   logic                 rsp_valid_ff;
   chp_pkg::result_type  rsp_ff, rsp_in;

   // shared byte-level terms
   logic        take;
   logic        sat;
   logic [7:0]  b;
   logic [chp_pkg::POS_W-1:0] nxt;
   logic [16:0] nxt_x;
   logic [16:0] pos_x;
   logic [15:0] acc_shift;
   logic [23:0] plen_shift;
   logic        at_fend;
   logic        at_len_end;
   logic [16:0] ext_end;
   logic        at_ext_end;
   logic        walk_active;
   logic [16:0] rel;
   logic [17:0] hdr4;
   logic        hdr4_over;
   logic [17:0] data_end;
   logic        data_over;
   logic        type_hit;
   logic        msg_ok;
   logic        ext_present;

   assign take        = req_tvalid && req_tready;
   assign req_tready  = !rsp_valid_ff || rsp_tready || !req_tlast;
   assign b           = req_tdata;
   assign sat         = (pos_ff >= chp_pkg::POS_W'(chp_pkg::MAX_MSG_LEN));
   assign nxt         = pos_ff + 1'b1;
   assign nxt_x       = {2'b00, nxt};
   assign pos_x       = {2'b00, pos_ff};
   assign acc_shift   = {acc_ff[7:0], b};
   assign plen_shift  = {plen_ff[15:0], b};
   assign at_fend     = (nxt_x == fend_ff);
   assign at_len_end  = (nxt == chp_pkg::LEN_END);
   assign ext_end     = {2'b00, ebs_ff} + {1'b0, ebl_ff};
   assign at_ext_end  = (nxt_x == ext_end);

   // extension header walk terms, fend_ff holds the current header position
   assign walk_active = !found_ff && !stop_ff && (pos_x >= fend_ff);
   assign rel         = pos_x - fend_ff;
   assign hdr4        = {1'b0, fend_ff} + chp_pkg::EXT_HDR_LEN;
   assign hdr4_over   = (hdr4 > {1'b0, ext_end});
   assign data_end    = hdr4 + {2'b00, acc_shift};
   assign data_over   = (data_end > {1'b0, ext_end});
   assign type_hit    = (cur_ff == target_ff);

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (take && !sat) begin
         unique case (phase_ff)
            chp_pkg::PH_TYPE: begin
               phase_in = (b == chp_pkg::HELLO_TYPE) ? chp_pkg::PH_LEN : chp_pkg::PH_DONE;
            end
            chp_pkg::PH_LEN: begin
               if (at_len_end) begin
                  phase_in = (plen_shift < chp_pkg::MIN_PAYLOAD) ?
                             chp_pkg::PH_DONE : chp_pkg::PH_RANDOM;
               end
            end
            chp_pkg::PH_RANDOM: begin
               if (at_fend) phase_in = chp_pkg::PH_SIDLEN;
            end
            chp_pkg::PH_SIDLEN: begin
               phase_in = (b == 8'd0) ? chp_pkg::PH_CSLEN : chp_pkg::PH_SID;
            end
            chp_pkg::PH_SID: begin
               if (at_fend) phase_in = chp_pkg::PH_CSLEN;
            end
            chp_pkg::PH_CSLEN: begin
               if (at_fend) begin
                  if (acc_shift[0]) begin
                     phase_in = chp_pkg::PH_DONE;
                  end else if (acc_shift == 16'd0) begin
                     phase_in = chp_pkg::PH_COMPLEN;
                  end else begin
                     phase_in = chp_pkg::PH_CS;
                  end
               end
            end
            chp_pkg::PH_CS: begin
               if (at_fend) phase_in = chp_pkg::PH_COMPLEN;
            end
            chp_pkg::PH_COMPLEN: begin
               phase_in = (b == 8'd0) ? chp_pkg::PH_EXTLEN : chp_pkg::PH_COMP;
            end
            chp_pkg::PH_COMP: begin
               if (at_fend) phase_in = chp_pkg::PH_EXTLEN;
            end
            chp_pkg::PH_EXTLEN: begin
               if (at_fend) begin
                  phase_in = (acc_shift == 16'd0) ? chp_pkg::PH_DONE : chp_pkg::PH_EXT;
               end
            end
            chp_pkg::PH_EXT: begin
               if (at_ext_end) phase_in = chp_pkg::PH_DONE;
            end
            default: begin
               phase_in = chp_pkg::PH_DONE;
            end
         endcase
      end
   end

   // field registers and checks for the byte in flight
   always_comb begin
      pos_in   = pos_ff;
      plen_in  = plen_ff;
      acc_in   = acc_ff;
      fend_in  = fend_ff;
      sid_in   = sid_ff;
      cs_in    = cs_ff;
      comp_in  = comp_ff;
      ebs_in   = ebs_ff;
      ebl_in   = ebl_ff;
      cur_in   = cur_ff;
      found_in = found_ff;
      moff_in  = moff_ff;
      mlen_in  = mlen_ff;
      stop_in  = stop_ff;
      ferr_in  = ferr_ff;
      if (take) begin
         if (sat) begin
            // oversized message, extra bytes are not parsed
            ferr_in = 1'b1;
         end else begin
            pos_in = nxt;
            unique case (phase_ff)
               chp_pkg::PH_TYPE: begin
                  if (b != chp_pkg::HELLO_TYPE) ferr_in = 1'b1;
                  else plen_in = 24'd0;
               end
               chp_pkg::PH_LEN: begin
                  plen_in = plen_shift;
                  if (at_len_end) begin
                     if (plen_shift < chp_pkg::MIN_PAYLOAD) ferr_in = 1'b1;
                     else fend_in = chp_pkg::RANDOM_END;
                  end
               end
               chp_pkg::PH_RANDOM: begin
               end
               chp_pkg::PH_SIDLEN: begin
                  sid_in = b;
                  if (b == 8'd0) begin
                     fend_in = nxt_x + 17'd2;
                     acc_in  = 16'd0;
                  end else begin
                     fend_in = nxt_x + {9'd0, b};
                  end
               end
               chp_pkg::PH_SID: begin
                  if (at_fend) begin
                     fend_in = nxt_x + 17'd2;
                     acc_in  = 16'd0;
                  end
               end
               chp_pkg::PH_CSLEN: begin
                  acc_in = acc_shift;
                  if (at_fend) begin
                     cs_in = acc_shift;
                     if (acc_shift[0]) ferr_in = 1'b1;
                     else fend_in = nxt_x + {1'b0, acc_shift};
                  end
               end
               chp_pkg::PH_CS: begin
               end
               chp_pkg::PH_COMPLEN: begin
                  comp_in = b;
                  if (b == 8'd0) begin
                     fend_in = nxt_x + 17'd2;
                     acc_in  = 16'd0;
                  end else begin
                     fend_in = nxt_x + {9'd0, b};
                  end
               end
               chp_pkg::PH_COMP: begin
                  if (at_fend) begin
                     fend_in = nxt_x + 17'd2;
                     acc_in  = 16'd0;
                  end
               end
               chp_pkg::PH_EXTLEN: begin
                  acc_in = acc_shift;
                  if (at_fend) begin
                     ebl_in  = acc_shift;
                     ebs_in  = nxt;
                     fend_in = nxt_x;
                     cur_in  = 16'd0;
                  end
               end
               chp_pkg::PH_EXT: begin
                  // walk the four header bytes of the current extension
                  if (walk_active) begin
                     if (rel == 17'd0 && hdr4_over) begin
                        stop_in = 1'b1;
                     end else if (rel == 17'd0 || rel == 17'd1) begin
                        cur_in = {cur_ff[7:0], b};
                     end else if (rel == 17'd2) begin
                        acc_in = {8'd0, b};
                     end else if (rel == 17'd3) begin
                        acc_in = acc_shift;
                        if (data_over) begin
                           stop_in = 1'b1;
                        end else if (type_hit) begin
                           found_in = 1'b1;
                           moff_in  = hdr4[13:0];
                           mlen_in  = acc_shift;
                        end else begin
                           fend_in = data_end[16:0];
                        end
                     end
                  end
               end
               default: begin
                  // any byte after the layout has ended or been rejected
                  ferr_in = 1'b1;
               end
            endcase
         end
      end
   end

   // end-of-message checks on the updated state
   assign ext_present = (phase_in == chp_pkg::PH_DONE);
   assign msg_ok = !ferr_in
                   && (({1'b0, plen_in} + chp_pkg::MSG_HDR_LEN) == {10'd0, pos_in})
                   && (ext_present
                       || (phase_in == chp_pkg::PH_EXTLEN
                           && fend_in == ({2'b00, pos_in} + 17'd2)));

   // result fields, all zero unless the message is valid
   always_comb begin
      rsp_in = '0;
      if (msg_ok) begin
         rsp_in.hello_valid       = 1'b1;
         rsp_in.session_id_len    = sid_in;
         rsp_in.cipher_suites_len = cs_in;
         rsp_in.compression_len   = comp_in;
         if (ext_present) begin
            rsp_in.ext_block_present = 1'b1;
            rsp_in.ext_block_offset  = ebs_in[13:0];
            rsp_in.ext_block_len     = ebl_in;
            if (found_in) begin
               rsp_in.ext_found       = 1'b1;
               rsp_in.ext_data_offset = moff_in;
               rsp_in.ext_data_len    = mlen_in;
            end
         end
      end
   end

   // parse control state, cleared after every last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= chp_pkg::PH_TYPE;
         pos_ff   <= '0;
         found_ff <= 1'b0;
         stop_ff  <= 1'b0;
         ferr_ff  <= 1'b0;
      end else if (take) begin
         if (req_tlast) begin
            phase_ff <= chp_pkg::PH_TYPE;
            pos_ff   <= '0;
            found_ff <= 1'b0;
            stop_ff  <= 1'b0;
            ferr_ff  <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            found_ff <= found_in;
            stop_ff  <= stop_in;
            ferr_ff  <= ferr_in;
         end
      end
   end

   // parse payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         plen_ff <= plen_in;
         acc_ff  <= acc_in;
         fend_ff <= fend_in;
         sid_ff  <= sid_in;
         cs_ff   <= cs_in;
         comp_ff <= comp_in;
         ebs_ff  <= ebs_in;
         ebl_ff  <= ebl_in;
         cur_ff  <= cur_in;
         moff_ff <= moff_in;
         mlen_ff <= mlen_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_tlast) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // configuration register write and read
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= chp_pkg::TARGET_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == chp_pkg::CSR_IDX_TARGET) begin
         target_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == chp_pkg::CSR_IDX_TARGET) ? {16'd0, target_ff} : 32'd0;

   // checks
   `CHP_ASSERT_IMPL(a_no_result_overwrite, clock, reset,
                    rsp_tvalid && !rsp_tready && req_tvalid && req_tlast, !req_tready)
   `CHP_ASSERT_NEXT(a_last_gives_result, clock, reset,
                    req_tvalid && req_tready && req_tlast, rsp_tvalid)
   `CHP_ASSERT_IMPL(a_invalid_is_zero, clock, reset,
                    rsp_tvalid && !rsp_tdata[0], rsp_tdata[95:1] == 95'd0)
   `CHP_ASSERT_IMPL(a_found_needs_block, clock, reset,
                    rsp_tvalid && rsp_tdata[64], rsp_tdata[33] && rsp_tdata[0])

endmodule
